/* rtl/core/clld_pkg.sv */
`default_nettype none

package clld_pkg;

  typedef enum logic [2:0] {
    MODE_START,
    MODE_CODE,
    MODE_SUF0,
    MODE_SUF1,
    MODE_SUF2,
    MODE_COPY
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic        error;
    logic [31:0] error_line;
  } out_item_t;

  localparam int CMD_BYTES = 6;

  // one front-end decision: up to six bytes or one error
  typedef struct packed {
    logic [CMD_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      error;
    logic [31:0]               error_line;
  } cmd_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [9:0] CODE_MAX         = 10'd1023;
  localparam logic [9:0] CODE_HASH        = 10'd0;
  localparam logic [9:0] CODE_LAST_NUM    = 10'd100;
  localparam logic [9:0] CODE_FIRST_SEX   = 10'd101;
  localparam logic [9:0] CODE_LAST_SEX    = 10'd105;
  localparam logic [9:0] CODE_FIRST_LTR   = 10'd106;
  localparam logic [9:0] CODE_LAST_LTR    = 10'd127;
  localparam logic [9:0] CODE_CHR         = 10'd200;
  localparam logic [9:0] CODE_NONE        = 10'd300;

  localparam logic [9:0] SUF_LETTER_LO    = 10'd100;
  localparam logic [9:0] SUF_LETTER_END   = 10'd152;
  localparam logic [9:0] SUF_RAW_LO       = 10'd200;
  localparam logic [9:0] SUF_RAW_END      = 10'd456;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_R     = 8'h72;

  function automatic logic [7:0] sex_tail(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h58;  // X
      3'd1:    ch = 8'h59;  // Y
      3'd2:    ch = 8'h57;  // W
      3'd3:    ch = 8'h5A;  // Z
      3'd4:    ch = 8'h4D;  // M
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/clld_front.sv */
`default_nettype none

module clld_front #(
  parameter int LINE_NUMBER_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire clld_pkg::in_item_t in_item,
  output logic                   cmd_valid,
  output clld_pkg::cmd_t         cmd
);

  clld_pkg::mode_t mode_r, mode_nxt;
  logic [9:0]  code_r, code_nxt;
  logic [9:0]  suf_r, suf_nxt;
  logic [LINE_NUMBER_BITS-1:0] line_r, line_nxt;
  logic        halted_r, halted_nxt;

  logic [7:0]  b;
  logic        at_start, active;
  logic        is_dig, is_spc, is_nl, is_dot, is_hash;
  logic [3:0]  dig;
  clld_pkg::mode_t eff_mode;
  logic [9:0]  cv;
  logic [13:0] code_prod;
  logic [9:0]  code_sat;
  logic [13:0] suf_prod;
  logic [9:0]  suf_w, suf_ltr, suf_raw;
  logic        ltr_ok, raw_ok, suf_ok;
  logic        code_delim, name_ok;
  logic [6:0]  num_v;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  ones_w;
  logic [9:0]  sex_idx, ltr_idx;
  logic [LINE_NUMBER_BITS-1:0] line_inc;
  logic [31:0] err_line;

  assign b        = in_item.end_of_input ? clld_pkg::CH_NL : in_item.data_byte;
  assign at_start = (mode_r == clld_pkg::MODE_START);
  assign active   = in_valid && !halted_r && !(in_item.end_of_input && at_start);

  assign is_dig  = (b >= clld_pkg::CH_0) && (b <= clld_pkg::CH_9);
  assign is_spc  = (b == clld_pkg::CH_SPACE) || ((b >= clld_pkg::CH_TAB) && (b <= clld_pkg::CH_CR));
  assign is_nl   = (b == clld_pkg::CH_NL);
  assign is_dot  = (b == clld_pkg::CH_DOT);
  assign is_hash = (b == clld_pkg::CH_HASH);
  assign dig     = b[3:0];

  assign eff_mode = at_start ? clld_pkg::MODE_CODE : mode_r;
  assign cv       = at_start ? 10'd0 : code_r;

  assign code_prod = {4'b0, cv} * 14'd10 + {10'b0, dig};
  assign code_sat  = (code_prod > {4'b0, clld_pkg::CODE_MAX}) ? clld_pkg::CODE_MAX
                                                              : code_prod[9:0];

  assign suf_prod = {4'b0, suf_r} * 14'd10 + {10'b0, dig};
  assign suf_w    = suf_prod[9:0];
  assign ltr_ok   = (suf_w >= clld_pkg::SUF_LETTER_LO) && (suf_w < clld_pkg::SUF_LETTER_END);
  assign raw_ok   = (suf_w >= clld_pkg::SUF_RAW_LO) && (suf_w < clld_pkg::SUF_RAW_END);
  assign suf_ok   = ltr_ok || raw_ok;
  assign suf_ltr  = suf_w - clld_pkg::SUF_LETTER_LO;
  assign suf_raw  = suf_w - clld_pkg::SUF_RAW_LO;

  assign code_delim = is_dot || is_nl || is_spc;
  assign name_ok    = (cv <= clld_pkg::CODE_LAST_LTR) || (cv == clld_pkg::CODE_CHR) ||
                      (cv == clld_pkg::CODE_NONE);

  // decimal split of code-1, exact for values below 100
  assign num_v     = cv[6:0] - 7'd1;
  assign tens_prod = {8'b0, num_v} * 15'd205;
  assign tens      = tens_prod[14:11];
  assign ones_w    = num_v - {3'b0, tens} * 7'd10;
  assign sex_idx   = cv - clld_pkg::CODE_FIRST_SEX;
  assign ltr_idx   = cv - clld_pkg::CODE_FIRST_LTR;

  assign line_inc = line_r + 1'b1;

  generate
    if (LINE_NUMBER_BITS >= 32) begin : g_line_wide
      assign err_line = line_inc[31:0];
    end else begin : g_line_narrow
      assign err_line = {{(32-LINE_NUMBER_BITS){1'b0}}, line_inc};
    end
  endgenerate

  // next state
  always_comb begin
    mode_nxt   = mode_r;
    code_nxt   = code_r;
    suf_nxt    = suf_r;
    line_nxt   = line_r;
    halted_nxt = halted_r;
    if (active) begin
      priority if (at_start && is_nl) begin
        line_nxt = line_inc;
        mode_nxt = clld_pkg::MODE_START;
      end else if (at_start && is_hash) begin
        mode_nxt = clld_pkg::MODE_COPY;
      end else begin
        unique case (eff_mode)
          clld_pkg::MODE_CODE: begin
            if (is_dig) begin
              code_nxt = code_sat;
              mode_nxt = clld_pkg::MODE_CODE;
            end else if (!code_delim || !name_ok) begin
              halted_nxt = 1'b1;
            end else if (is_dot) begin
              mode_nxt = clld_pkg::MODE_SUF0;
            end else if (is_nl) begin
              line_nxt = line_inc;
              mode_nxt = clld_pkg::MODE_START;
            end else begin
              mode_nxt = clld_pkg::MODE_COPY;
            end
          end
          clld_pkg::MODE_SUF0: begin
            if (is_dig) begin
              suf_nxt  = {6'b0, dig};
              mode_nxt = clld_pkg::MODE_SUF1;
            end else if (is_nl) begin
              line_nxt = line_inc;
              mode_nxt = clld_pkg::MODE_START;
            end else if (is_spc) begin
              mode_nxt = clld_pkg::MODE_COPY;
            end else begin
              halted_nxt = 1'b1;
            end
          end
          clld_pkg::MODE_SUF1: begin
            if (!is_dig) begin
              halted_nxt = 1'b1;
            end else begin
              suf_nxt  = suf_w;
              mode_nxt = (suf_w < 10'd10) ? clld_pkg::MODE_SUF0 : clld_pkg::MODE_SUF2;
            end
          end
          clld_pkg::MODE_SUF2: begin
            if (!is_dig || !suf_ok) begin
              halted_nxt = 1'b1;
            end else begin
              suf_nxt  = suf_w;
              mode_nxt = clld_pkg::MODE_SUF0;
            end
          end
          clld_pkg::MODE_COPY: begin
            if (is_nl) begin
              line_nxt = line_inc;
              mode_nxt = clld_pkg::MODE_START;
            end
          end
          default: mode_nxt = clld_pkg::MODE_START;
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    logic [4:0][7:0] name;
    logic [2:0]      nlen;
    logic            fail;
    name      = '0;
    nlen      = 3'd0;
    fail      = 1'b0;
    cmd       = '0;
    cmd_valid = 1'b0;
    if (active && !(at_start && (is_nl || is_hash))) begin
      unique case (eff_mode)
        clld_pkg::MODE_CODE: begin
          if (!is_dig) begin
            if (!code_delim || !name_ok) begin
              fail = 1'b1;
            end else begin
              priority if (cv == clld_pkg::CODE_HASH) begin
                name[0] = clld_pkg::CH_HASH;
                nlen    = 3'd1;
              end else if (cv == clld_pkg::CODE_NONE) begin
                nlen = 3'd0;
              end else begin
                name[0] = clld_pkg::CH_C;
                name[1] = clld_pkg::CH_H;
                name[2] = clld_pkg::CH_R;
                priority if (cv <= clld_pkg::CODE_LAST_NUM) begin
                  if (num_v >= 7'd10) begin
                    name[3] = clld_pkg::CH_0 + {4'b0, tens};
                    name[4] = clld_pkg::CH_0 + {4'b0, ones_w[3:0]};
                    nlen    = 3'd5;
                  end else begin
                    name[3] = clld_pkg::CH_0 + {4'b0, ones_w[3:0]};
                    nlen    = 3'd4;
                  end
                end else if (cv <= clld_pkg::CODE_LAST_SEX) begin
                  name[3] = clld_pkg::sex_tail(sex_idx[2:0]);
                  nlen    = 3'd4;
                end else if (cv <= clld_pkg::CODE_LAST_LTR) begin
                  name[3] = clld_pkg::CH_UA + ltr_idx[7:0];
                  nlen    = 3'd4;
                end else begin
                  nlen = 3'd3;
                end
              end
              cmd.bytes = {8'h00, name};
              if (is_dot) begin
                cmd.count = nlen;
              end else begin
                cmd.bytes[nlen] = b;
                cmd.count       = nlen + 3'd1;
              end
            end
          end
        end
        clld_pkg::MODE_SUF0: begin
          if (is_nl || is_spc) begin
            cmd.bytes[0] = b;
            cmd.count    = 3'd1;
          end else if (!is_dig) begin
            fail = 1'b1;
          end
        end
        clld_pkg::MODE_SUF1: begin
          if (!is_dig) begin
            fail = 1'b1;
          end else if (suf_w < 10'd10) begin
            cmd.bytes[0] = clld_pkg::CH_0 + {4'b0, suf_w[3:0]};
            cmd.count    = 3'd1;
          end
        end
        clld_pkg::MODE_SUF2: begin
          if (!is_dig || !suf_ok) begin
            fail = 1'b1;
          end else if (ltr_ok) begin
            cmd.bytes[0] = (suf_w[0] ? clld_pkg::CH_LA : clld_pkg::CH_UA) +
                           {2'b0, suf_ltr[6:1]};
            cmd.count    = 3'd1;
          end else begin
            cmd.bytes[0] = suf_raw[7:0];
            cmd.count    = 3'd1;
          end
        end
        clld_pkg::MODE_COPY: begin
          cmd.bytes[0] = b;
          cmd.count    = 3'd1;
        end
        default: cmd.count = 3'd0;
      endcase
      if (fail) begin
        cmd            = '0;
        cmd.count      = 3'd1;
        cmd.error      = 1'b1;
        cmd.error_line = err_line;
      end
      cmd_valid = (cmd.count != 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= clld_pkg::MODE_START;
      code_r   <= '0;
      suf_r    <= '0;
      line_r   <= '0;
      halted_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      code_r   <= code_nxt;
      suf_r    <= suf_nxt;
      line_r   <= line_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/clld_queue.sv */
`default_nettype none

module clld_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire clld_pkg::cmd_t  wr_data,
  output logic                 full,
  input  wire logic            rd_en,
  output clld_pkg::cmd_t       rd_data,
  output logic                 nonempty
);

  clld_pkg::cmd_t              mem_r [clld_pkg::QUEUE_DEPTH];
  logic [clld_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [clld_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [clld_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic                        do_wr, do_rd;

  assign full     = (count_r == clld_pkg::QCNT_W'(clld_pkg::QUEUE_DEPTH));
  assign nonempty = (count_r != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && nonempty;
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == clld_pkg::QPTR_W'(clld_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == clld_pkg::QPTR_W'(clld_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/clld_back.sv */
`default_nettype none

module clld_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  input  wire clld_pkg::cmd_t  head,
  output logic                 head_done,
  output logic                 empty,
  input  wire logic            pop,
  output clld_pkg::out_item_t  out_item
);

  logic [2:0]          idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  clld_pkg::out_item_t out_r, out_nxt;
  logic                load, is_last;

  assign empty    = !out_valid_r;
  assign out_item = out_r;
  assign load     = head_valid && (!out_valid_r || pop);
  assign is_last  = (idx_r == head.count - 3'd1);
  assign head_done = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !pop;
    if (load) begin
      out_nxt.out_byte   = head.bytes[idx_r];
      out_nxt.last       = is_last;
      out_nxt.error      = head.error;
      out_nxt.error_line = head.error_line;
      out_valid_nxt      = 1'b1;
      idx_nxt            = is_last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/chrom_label_line_decoder.sv */
// Chromosome label line decoder. Text bytes enter through a queue-style port (push/full) and
// decoded bytes leave through another (empty/pop). The parser takes one input item per cycle
// whenever its two-entry command queue has room; every item resolves in that cycle into zero
// to six output bytes or one error. The output serializer drains one byte per cycle while the
// consumer pops, so an item that expands to k bytes holds the back end until all k are loaded,
// and the queue and output register absorb the difference. After an error transfer the block
// emits nothing further until reset, but keeps taking input.
`default_nettype none

module chrom_label_line_decoder #(
  parameter int LINE_NUMBER_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire clld_pkg::in_item_t in_data,
  output logic                    empty,
  input  wire logic               pop,
  output clld_pkg::out_item_t     out_data
);

  logic           in_xfer;
  logic           cmd_valid;
  clld_pkg::cmd_t cmd;
  logic           q_full, q_nonempty, q_rd;
  clld_pkg::cmd_t q_head;

  assign full    = q_full;
  assign in_xfer = push && !q_full;

  clld_front #(
    .LINE_NUMBER_BITS(LINE_NUMBER_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_xfer),
    .in_item  (in_data),
    .cmd_valid(cmd_valid),
    .cmd      (cmd)
  );

  clld_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_head),
    .nonempty(q_nonempty)
  );

  clld_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(q_nonempty),
    .head      (q_head),
    .head_done (q_rd),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_data)
  );

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.error) |-> out_data.last)
    else $error("error result without last");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_valid && q_full))
    else $error("command written into full queue");

  a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && out_data.error) |=> empty)
    else $error("result after error transfer");

  a_byte_no_line: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.error) |-> (out_data.error_line == 32'd0))
    else $error("byte result carries error line");

endmodule

`default_nettype wire

/* verif/tb_chrom_label_line_decoder.sv */
`default_nettype none

module tb_chrom_label_line_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import clld_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 20;

  class label_scoreboard;
    mode_t       mode;
    int          code_acc;
    int          suf_acc;
    logic [31:0] lines_done;
    bit          halted;
    out_item_t   decoded_q[$];
    logic [7:0]  step_bytes[$];
    int          mismatches;

    function new();
      mode       = MODE_START;
      code_acc   = 0;
      suf_acc    = 0;
      lines_done = '0;
      halted     = 1'b0;
      mismatches = 0;
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= CH_0 && b <= CH_9;
    endfunction

    function bit is_space(logic [7:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function void end_line();
      lines_done++;
      mode = MODE_START;
    endfunction

    // name bytes for the line code; 0 when the code is not a valid label
    function bit put_label(int c);
      if (c == CODE_HASH) begin
        step_bytes.push_back(CH_HASH);
        return 1'b1;
      end
      if (c == CODE_NONE) return 1'b1;
      if (c > CODE_LAST_LTR && c != CODE_CHR) return 1'b0;
      step_bytes.push_back(CH_C);
      step_bytes.push_back(CH_H);
      step_bytes.push_back(CH_R);
      if (c <= CODE_LAST_NUM) begin
        if (c - 1 >= 10) step_bytes.push_back(8'(CH_0 + (c - 1) / 10));
        step_bytes.push_back(8'(CH_0 + (c - 1) % 10));
      end else if (c <= CODE_LAST_SEX) begin
        case (c - CODE_FIRST_SEX)
          0:       step_bytes.push_back("X");
          1:       step_bytes.push_back("Y");
          2:       step_bytes.push_back("W");
          3:       step_bytes.push_back("Z");
          default: step_bytes.push_back("M");
        endcase
      end else if (c <= CODE_LAST_LTR) begin
        step_bytes.push_back(8'(CH_UA + (c - CODE_FIRST_LTR)));
      end
      return 1'b1;
    endfunction

    function void decode_item(in_item_t it);
      logic [7:0] b;
      int         v;
      bit         bad;
      out_item_t  r;
      step_bytes.delete();
      bad = 1'b0;
      b   = it.data_byte;
      if (halted) return;
      if (it.end_of_input) begin
        if (mode == MODE_START) return;
        b = CH_NL;
      end
      if (mode == MODE_START) begin
        if (b == CH_NL) begin
          end_line();
          return;
        end
        if (b == CH_HASH) begin
          mode = MODE_COPY;
          return;
        end
        code_acc = 0;
        mode     = MODE_CODE;
      end
      case (mode)
        MODE_CODE: begin
          if (is_digit(b)) begin
            v        = code_acc * 10 + (b - CH_0);
            code_acc = (v > CODE_MAX) ? CODE_MAX : v;
          end else if (b != CH_DOT && b != CH_NL && !is_space(b)) begin
            bad = 1'b1;
          end else if (!put_label(code_acc)) begin
            bad = 1'b1;
          end else if (b == CH_DOT) begin
            mode = MODE_SUF0;
          end else begin
            step_bytes.push_back(b);
            if (b == CH_NL) end_line();
            else mode = MODE_COPY;
          end
        end
        MODE_SUF0: begin
          if (is_digit(b)) begin
            suf_acc = b - CH_0;
            mode    = MODE_SUF1;
          end else if (b == CH_NL) begin
            step_bytes.push_back(b);
            end_line();
          end else if (is_space(b)) begin
            step_bytes.push_back(b);
            mode = MODE_COPY;
          end else begin
            bad = 1'b1;
          end
        end
        MODE_SUF1: begin
          if (!is_digit(b)) begin
            bad = 1'b1;
          end else begin
            suf_acc = suf_acc * 10 + (b - CH_0);
            if (suf_acc < 10) begin
              step_bytes.push_back(8'(CH_0 + suf_acc));
              mode = MODE_SUF0;
            end else begin
              mode = MODE_SUF2;
            end
          end
        end
        MODE_SUF2: begin
          if (!is_digit(b)) begin
            bad = 1'b1;
          end else begin
            suf_acc = suf_acc * 10 + (b - CH_0);
            if (suf_acc >= SUF_LETTER_LO && suf_acc < SUF_LETTER_END) begin
              if (suf_acc % 2 == 0)
                step_bytes.push_back(8'(CH_UA + (suf_acc - SUF_LETTER_LO) / 2));
              else
                step_bytes.push_back(8'(CH_LA + (suf_acc - SUF_LETTER_LO - 1) / 2));
              mode = MODE_SUF0;
            end else if (suf_acc >= SUF_RAW_LO && suf_acc < SUF_RAW_END) begin
              step_bytes.push_back(8'(suf_acc - SUF_RAW_LO));
              mode = MODE_SUF0;
            end else begin
              bad = 1'b1;
            end
          end
        end
        MODE_COPY: begin
          step_bytes.push_back(b);
          if (b == CH_NL) end_line();
        end
        default: mode = MODE_START;
      endcase
      if (bad) begin
        r.out_byte   = '0;
        r.last       = 1'b1;
        r.error      = 1'b1;
        r.error_line = lines_done + 1;
        decoded_q.push_back(r);
        halted = 1'b1;
        return;
      end
      foreach (step_bytes[i]) begin
        r.out_byte   = step_bytes[i];
        r.last       = (i == step_bytes.size() - 1);
        r.error      = 1'b0;
        r.error_line = '0;
        decoded_q.push_back(r);
      end
    endfunction

    function void match_output(out_item_t got);
      out_item_t want;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected output byte %h last %b err %b line %0d",
                 $time, got.out_byte, got.last, got.error, got.error_line);
        mismatches++;
        return;
      end
      want = decoded_q.pop_front();
      if (got.out_byte !== want.out_byte || got.last !== want.last ||
          got.error !== want.error || got.error_line !== want.error_line) begin
        $display("%0t: expected byte %h last %b err %b line %0d, got byte %h last %b err %b line %0d",
                 $time, want.out_byte, want.last, want.error, want.error_line,
                 got.out_byte, got.last, got.error, got.error_line);
        mismatches++;
      end
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_item_t  in_data = '0;
  logic      full;
  logic      empty;
  out_item_t out_data;

  label_scoreboard sb;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int items_sent    = 0;
  int quiet_cycles  = 0;

  chrom_label_line_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // result side: check each transfer, then pick pop for the next edge
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.match_output(out_data);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("chrom_label_line_decoder: mismatch");
      $finish;
    end
  end

  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    sb.decode_item(it);
    items_sent++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    in_item_t it;
    it.data_byte    = b;
    it.end_of_input = 1'b0;
    send_item(it);
  endtask

  task automatic push_eoi();
    in_item_t it;
    it.data_byte    = 8'($urandom_range(0, 255));
    it.end_of_input = 1'b1;
    send_item(it);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 4))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return 8'h0B;
      3:       return 8'h0C;
      default: return CH_CR;
    endcase
  endfunction

  // rest of a line in copy mode, closed by newline or end of stream
  task automatic copy_tail();
    int         n;
    logic [7:0] b;
    n = $urandom_range(0, 8);
    repeat (n) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
      push_byte(b);
    end
    if ($urandom_range(0, 3) == 0) push_eoi();
    else push_byte(CH_NL);
  endtask

  task automatic line_end_after_suffix();
    case ($urandom_range(0, 2))
      0: begin
        push_byte(rand_space());
        copy_tail();
      end
      1:       push_byte(CH_NL);
      default: push_eoi();
    endcase
  endtask

  task automatic gen_line();
    int    c;
    int    groups;
    string s;
    case ($urandom_range(0, 19))
      0: push_byte(CH_NL);
      1: push_eoi();
      2: begin
        push_byte(CH_HASH);
        copy_tail();
      end
      default: begin
        case ($urandom_range(0, 7))
          0:       c = CODE_HASH;
          1:       c = $urandom_range(1, CODE_LAST_NUM);
          2:       c = $urandom_range(CODE_FIRST_SEX, CODE_LAST_SEX);
          3:       c = $urandom_range(CODE_FIRST_LTR, CODE_LAST_LTR);
          4:       c = CODE_CHR;
          5:       c = CODE_NONE;
          6:       c = $urandom_range(1, CODE_LAST_LTR);
          default: c = ($urandom_range(0, 1) != 0) ? 1 : CODE_LAST_NUM;
        endcase
        s = $sformatf("%0d", c);
        repeat ($urandom_range(0, 2)) s = {"0", s};
        if (c == CODE_HASH && $urandom_range(0, 2) == 0) s = "";
        push_str(s);
        case ($urandom_range(0, 5))
          0, 1: begin
            push_byte(CH_DOT);
            groups = $urandom_range(0, 3);
            repeat (groups) begin
              case ($urandom_range(0, 2))
                0:       push_str($sformatf("0%0d", $urandom_range(0, 9)));
                1:       push_str($sformatf("%0d", $urandom_range(SUF_LETTER_LO,
                                                                  SUF_LETTER_END - 1)));
                default: push_str($sformatf("%0d", $urandom_range(SUF_RAW_LO,
                                                                  SUF_RAW_END - 1)));
              endcase
            end
            line_end_after_suffix();
          end
          2, 3: begin
            push_byte(rand_space());
            copy_tail();
          end
          4:       push_byte(CH_NL);
          default: push_eoi();
        endcase
      end
    endcase
  endtask

  // one malformed line; the block halts on it
  task automatic send_broken_line();
    case ($urandom_range(0, 7))
      0: begin
        push_str($sformatf("%0d", $urandom_range(1, CODE_LAST_LTR)));
        push_byte("q");
      end
      1:       push_str($sformatf("%0d ", $urandom_range(CODE_LAST_LTR + 1, CODE_CHR - 1)));
      2:       push_str("9999999\n");
      3:       push_str($sformatf("5.%0d\n", $urandom_range(SUF_LETTER_END, SUF_RAW_LO - 1)));
      4:       push_str($sformatf("5.%0d\n", $urandom_range(SUF_RAW_END, 999)));
      5:       push_str("12.1\n");
      6:       push_str("8.05x");
      default: begin
        push_str("3.4");
        push_eoi();
      end
    endcase
  endtask

  initial begin
    int target;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_str("127.151455\n");
    push_str("100 ");
    push_byte(8'h00);
    push_eoi();
    push_eoi();
    push_str("\n#");
    push_byte(8'h80);
    push_byte(CH_NL);
    push_str("300.0900200\t\n");

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 87;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 87;
        end
        default: begin
          send_idle_pct = 17;
          stall_pct     = 17;
        end
      endcase
      if (ph == 0) begin
        hold_req++;
        target = items_sent + 40;
        while (items_sent < target) gen_line();
      end
      target = items_sent + 85;
      while (items_sent < target) gen_line();
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    repeat ($urandom_range(0, 2)) gen_line();
    send_broken_line();
    repeat (6) gen_line();
    push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d decoded bytes never arrived", $time, sb.pending());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("chrom_label_line_decoder: match");
    end else begin
      $display("chrom_label_line_decoder: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/clld_pkg.sv
rtl/core/clld_front.sv
rtl/core/clld_queue.sv
rtl/core/clld_back.sv
rtl/core/chrom_label_line_decoder.sv
verif/tb_chrom_label_line_decoder.sv
